[src/acqr_pkg.sv]
// ----------------------------------------------------------------------------
// acqr_pkg - shared definitions for the channel quality router
// Widths, register reset values, microcode word layout and the control
// program that the sequencer steps through.
// ----------------------------------------------------------------------------
package acqr_pkg;

  // Sizing
  localparam int CHANNEL_COUNT = 4;
  localparam int COUNT_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int REG_COUNT     = 4;

  localparam int CH_W    = $clog2(CHANNEL_COUNT);
  localparam int THR_W   = 16;
  localparam int QUAL_W  = FRACTION_BITS + 1;
  localparam int CNT_W   = $clog2(FRACTION_BITS + 1);
  localparam int REG_W   = $clog2(REG_COUNT);
  localparam int ADDR_W  = REG_W + 2;
  localparam int APB_W   = 32;

  // Result beat layout
  localparam int CHAN_FIELD_W  = 2;
  localparam int TOTAL_FIELD_W = 32;
  localparam int OUT_W   = CHAN_FIELD_W + 1 + QUAL_W + 4 * TOTAL_FIELD_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int IN_TDATA_W  = 16;

  localparam logic [QUAL_W-1:0] QUALITY_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [THR_W-1:0] THR_RESET [REG_COUNT] = '{
    16'd1311, 16'd9830, 16'd39322, 16'd62259
  };

  // Microcode
  localparam int STEP_W = 3;
  localparam int OP_W   = 3;
  localparam int COND_W = 2;

  localparam logic [STEP_W-1:0] STEP_ACCEPT = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_UPDATE = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIV    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_RETIRE = 3'd4;

  localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT = 3'd1;
  localparam logic [OP_W-1:0] OP_SCAN   = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
  localparam logic [OP_W-1:0] OP_RETIRE = 3'd5;

  // NEXT: fall through; WAIT_IN: hold at target until a beat arrives;
  // LOOP: jump to target while the loop counter is non-zero;
  // RETIRE: hold while the output is occupied, then jump to target.
  localparam logic [COND_W-1:0] COND_NEXT    = 2'd0;
  localparam logic [COND_W-1:0] COND_WAIT_IN = 2'd1;
  localparam logic [COND_W-1:0] COND_LOOP    = 2'd2;
  localparam logic [COND_W-1:0] COND_RETIRE  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } acqr_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic loop_more;
    logic out_busy;
  } acqr_status_t;

  // Control program
  function automatic acqr_ctrl_t ucode(input logic [STEP_W-1:0] step);
    acqr_ctrl_t w;
    case (step)
      STEP_ACCEPT: w = '{op: OP_ACCEPT, cond: COND_WAIT_IN, target: STEP_ACCEPT};
      STEP_SCAN:   w = '{op: OP_SCAN,   cond: COND_LOOP,    target: STEP_SCAN};
      STEP_UPDATE: w = '{op: OP_UPDATE, cond: COND_NEXT,    target: STEP_UPDATE};
      STEP_DIV:    w = '{op: OP_DIV,    cond: COND_LOOP,    target: STEP_DIV};
      STEP_RETIRE: w = '{op: OP_RETIRE, cond: COND_RETIRE,  target: STEP_ACCEPT};
      default:     w = '{op: OP_NONE,   cond: COND_RETIRE,  target: STEP_ACCEPT};
    endcase
    return w;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage

[src/acqr_sequencer.sv]
// ----------------------------------------------------------------------------
// acqr_sequencer - microcode step counter
// Holds the step counter, reads the control word from the program table
// and resolves the conditional jumps from datapath status.
// ----------------------------------------------------------------------------
module acqr_sequencer
  import acqr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  acqr_status_t status,
  output acqr_ctrl_t   ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  assign ctrl = ucode(step);

  // Jump resolution
  always_comb begin
    case (ctrl.cond)
      COND_NEXT:    step_next = step + STEP_W'(1);
      COND_WAIT_IN: step_next = status.in_valid ? step + STEP_W'(1) : ctrl.target;
      COND_LOOP:    step_next = status.loop_more ? ctrl.target : step + STEP_W'(1);
      COND_RETIRE:  step_next = status.out_busy ? step : ctrl.target;
      default:      step_next = STEP_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule

[src/adaptive_channel_quality_router.sv]
// ----------------------------------------------------------------------------
// adaptive_channel_quality_router - quality driven packet channel picker
// Routes each packet to the best (high priority) or worst (low priority)
// channel, decides the drop, updates counters and recomputes quality.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready: s_tdata carries the random
//   draw, s_tuser the low priority flag. Each input beat gives exactly one
//   result beat on m_tvalid/m_tready with the chosen channel, the drop
//   flag, the channel's new quality and the four priority totals.
//   Thresholds are written through the APB port (one per channel, 16 bits
//   at byte address 4*i); write them only while the block is idle.
//   Steps: 1 accept step, one scan step per channel (4), 1 update step and
//   17 divider steps (one quotient bit each), then 1 retire step. A new
//   packet is taken only after the retire step of the last one; the
//   shift-subtract divider takes most of the steps.
//   A result beat sits in the output register; the next packet is taken
//   and worked on while it waits. Only a second result stalls, at its
//   retire step, until the first is taken.
//   Reset (synchronous) clears the channel counters and priority totals,
//   sets every quality to one and loads the threshold reset values.
// ----------------------------------------------------------------------------
module adaptive_channel_quality_router
  import acqr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] random_draw
  input  logic                   s_tuser,   // [0] low_priority
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [1:0] chosen_channel, [2] was_dropped, [19:3] channel_quality,
  // [51:20] high_delivered_total, [83:52] high_lost_total,
  // [115:84] low_delivered_total, [147:116] low_lost_total, rest zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [APB_W-1:0]       pwdata,
  output logic [APB_W-1:0]       prdata,
  output logic                   pready
);

  acqr_ctrl_t   ctrl;
  acqr_status_t status;

  logic [THR_W-1:0]       thr [REG_COUNT];
  logic [COUNT_WIDTH-1:0] sent [CHANNEL_COUNT];
  logic [COUNT_WIDTH-1:0] lost [CHANNEL_COUNT];
  logic [QUAL_W-1:0]      quality [CHANNEL_COUNT];
  logic [COUNT_WIDTH-1:0] high_delivered, high_lost, low_delivered, low_lost;

  logic                   pkt_low;
  logic [THR_W-1:0]       pkt_draw;
  logic [CH_W-1:0]        idx;
  logic [CH_W-1:0]        best;
  logic [QUAL_W-1:0]      best_q;
  logic [CNT_W-1:0]       cnt;
  logic                   dropped;
  logic [COUNT_WIDTH:0]   rem;
  logic [COUNT_WIDTH-1:0] divisor;
  logic [QUAL_W-1:0]      quot;

  logic                   in_fire;
  logic                   cfg_we;
  logic [REG_W-1:0]       cfg_idx;
  logic [QUAL_W-1:0]      scan_q;
  logic                   take;
  logic [THR_W-1:0]       best_thr;
  logic                   drop_now;
  logic [COUNT_WIDTH-1:0] sent_new, lost_new;
  logic                   div_ge;
  logic [COUNT_WIDTH-1:0] div_diff;
  logic [QUAL_W-1:0]      q_new;
  logic                   out_busy;

  acqr_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign out_busy         = m_tvalid && !m_tready;
  assign status.in_valid  = s_tvalid;
  assign status.loop_more = (cnt != '0);
  assign status.out_busy  = out_busy;

  assign s_tready = (ctrl.op == OP_ACCEPT);
  assign in_fire  = s_tvalid && s_tready;

  // APB register file
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;
  assign prdata  = APB_W'(thr[cfg_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) thr[i] <= THR_RESET[i];
    end else if (cfg_we) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (cfg_idx == REG_W'(i) && i < CHANNEL_COUNT) thr[i] <= pwdata[THR_W-1:0];
      end
    end
  end

  // Scan compare: first channel always taken, ties keep the lower index
  assign scan_q = quality[idx];
  assign take   = (idx == '0) || (pkt_low ? (scan_q < best_q) : (scan_q > best_q));

  // Threshold of the chosen channel; channels without a register never drop
  always_comb begin
    best_thr = '0;
    for (int i = 0; i < REG_COUNT; i++) begin
      if (i < CHANNEL_COUNT && best == CH_W'(i)) best_thr = thr[i];
    end
  end

  assign drop_now = pkt_draw < best_thr;
  assign sent_new = sat_inc(sent[best]);
  assign lost_new = drop_now ? sat_inc(lost[best]) : lost[best];

  // Divider step: compare, subtract, shift in the quotient bit
  assign div_ge   = rem >= {1'b0, divisor};
  assign div_diff = div_ge ? COUNT_WIDTH'(rem - {1'b0, divisor}) : rem[COUNT_WIDTH-1:0];
  assign q_new    = QUALITY_ONE - quot;

  // Packet, scan and divider registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ACCEPT: begin
        if (in_fire) begin
          pkt_low  <= s_tuser;
          pkt_draw <= s_tdata[THR_W-1:0];
          idx      <= '0;
          cnt      <= CNT_W'(CHANNEL_COUNT - 1);
        end
      end
      OP_SCAN: begin
        if (take) begin
          best   <= idx;
          best_q <= scan_q;
        end
        idx <= idx + CH_W'(1);
        if (cnt != '0) cnt <= cnt - CNT_W'(1);
      end
      OP_UPDATE: begin
        dropped <= drop_now;
        rem     <= {1'b0, lost_new};
        divisor <= sent_new;
        quot    <= '0;
        cnt     <= CNT_W'(FRACTION_BITS);
      end
      OP_DIV: begin
        quot <= {quot[QUAL_W-2:0], div_ge};
        rem  <= {div_diff, 1'b0};
        if (cnt != '0) cnt <= cnt - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Channel state and priority totals
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        sent[i]    <= '0;
        lost[i]    <= '0;
        quality[i] <= QUALITY_ONE;
      end
      high_delivered <= '0;
      high_lost      <= '0;
      low_delivered  <= '0;
      low_lost       <= '0;
    end else begin
      if (ctrl.op == OP_UPDATE) begin
        sent[best] <= sent_new;
        lost[best] <= lost_new;
        if (drop_now) begin
          if (pkt_low) low_lost <= sat_inc(low_lost);
          else         high_lost <= sat_inc(high_lost);
        end else begin
          if (pkt_low) low_delivered <= sat_inc(low_delivered);
          else         high_delivered <= sat_inc(high_delivered);
        end
      end
      if (ctrl.op == OP_RETIRE && !out_busy) quality[best] <= q_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.op == OP_RETIRE && !out_busy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_RETIRE && !out_busy) begin
      m_tdata <= OUT_TDATA_W'({
        TOTAL_FIELD_W'(low_lost),
        TOTAL_FIELD_W'(low_delivered),
        TOTAL_FIELD_W'(high_lost),
        TOTAL_FIELD_W'(high_delivered),
        q_new,
        dropped,
        CHAN_FIELD_W'(best)
      });
    end
  end

endmodule
